FILE: rtl/core/pmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmf_pkg - shared types and constants of the pose median filter
// field widths, register indexes and reset values used by all pmf modules
// ----------------------------------------------------------------------------
package pmf_pkg;

	localparam int DATA_W     = 16;                 // input sample width
	localparam int OUT_W      = 17;                 // filtered result width
	localparam int SUM_W      = 26;                 // calibration accumulator width
	localparam int CALIB_W    = 10;                 // init_samples / calib_count width
	localparam int WLEN_W     = 5;                  // window_len register width
	localparam int BIT_W      = $clog2(DATA_W);     // bit counter of the ranking unit
	localparam int DIV_CNT_W  = $clog2(SUM_W);      // step counter of the divider

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int S_TDATA_W  = 2 * DATA_W;
	localparam int M_TDATA_W  = ((2 * OUT_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - 2 * OUT_W;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 2'd1;

	localparam logic [CALIB_W-1:0] INIT_SAMPLES_RST = 10'd50;
	localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST   = 5'd3;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]  result_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

endpackage
`default_nettype wire

FILE: rtl/core/pmf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmf_div - serial signed divider for the zero offset
// restoring division, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module pmf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  pmf_pkg::sum_t                  dividend,
	input  logic [pmf_pkg::CALIB_W-1:0]    divisor,
	output logic                           done,
	output pmf_pkg::sample_t               quotient
);
	import pmf_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  neg_q;
	logic [SUM_W-1:0]      mag_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CALIB_W-1:0]    rem_q;

	logic [CALIB_W:0]      rem_sh;
	logic                  fits;
	logic [CALIB_W:0]      rem_diff;
	logic [SUM_W-1:0]      quo_signed;

	assign rem_sh   = {rem_q, mag_q[SUM_W-1]};
	assign fits     = rem_sh >= {1'b0, divisor};
	assign rem_diff = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[SUM_W-2:0], fits};
			// remainder stays below the divisor, so it fits the divisor width
			rem_q <= fits ? rem_diff[CALIB_W-1:0] : rem_sh[CALIB_W-1:0];
		end
	end

	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = sample_t'(quo_signed[DATA_W-1:0]);
	assign done       = done_q;

endmodule
`default_nettype wire

FILE: rtl/core/pmf_rank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmf_rank - bit-serial order statistic selection over the window
// walks the samples msb first and narrows a candidate mask per wanted rank
// ----------------------------------------------------------------------------
module pmf_rank #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pmf_pkg::sample_t   entries [DEPTH],
	input  logic [CNT_W-1:0]   win,
	output logic               done,
	output pmf_pkg::sample_t   lo,
	output pmf_pkg::sample_t   hi
);
	import pmf_pkg::*;

	function automatic logic [CNT_W-1:0] count_ones(input logic [DEPTH-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < DEPTH; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	logic [DATA_W-1:0] sh_q [DEPTH];
	logic [DEPTH-1:0]  mask_lo_q;
	logic [DEPTH-1:0]  mask_hi_q;
	logic [CNT_W-1:0]  k_lo_q;
	logic [CNT_W-1:0]  k_hi_q;
	logic [DATA_W-1:0] res_lo_q;
	logic [DATA_W-1:0] res_hi_q;
	logic [BIT_W-1:0]  bit_cnt_q;
	logic              busy_q;
	logic              done_q;

	logic              is_sign;
	logic [DEPTH-1:0]  cur_bit;
	logic [DEPTH-1:0]  win_mask;
	logic [DEPTH-1:0]  zero_lo;
	logic [DEPTH-1:0]  zero_hi;
	logic [CNT_W-1:0]  c_lo;
	logic [CNT_W-1:0]  c_hi;
	logic              take_lo0;
	logic              take_hi0;

	// sign bit is inverted so that unsigned ordering matches signed ordering
	assign is_sign = (bit_cnt_q == '0);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cur_bit[i]  = sh_q[i][DATA_W-1] ^ is_sign;
			win_mask[i] = (CNT_W'(i) < win);
		end
	end

	assign zero_lo  = mask_lo_q & ~cur_bit;
	assign zero_hi  = mask_hi_q & ~cur_bit;
	assign c_lo     = count_ones(zero_lo);
	assign c_hi     = count_ones(zero_hi);
	assign take_lo0 = k_lo_q < c_lo;
	assign take_hi0 = k_hi_q < c_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= '0;
			end else if (busy_q) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
				if (bit_cnt_q == BIT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < DEPTH; i++) begin
				sh_q[i] <= entries[i];
			end
			mask_lo_q <= win_mask;
			mask_hi_q <= win_mask;
			// lower and upper middle ranks, equal for an odd window
			k_lo_q    <= (win - 1'b1) >> 1;
			k_hi_q    <= win >> 1;
		end else if (busy_q) begin
			for (int i = 0; i < DEPTH; i++) begin
				sh_q[i] <= {sh_q[i][DATA_W-2:0], 1'b0};
			end
			if (take_lo0) begin
				mask_lo_q <= zero_lo;
				res_lo_q  <= {res_lo_q[DATA_W-2:0], 1'b0};
			end else begin
				mask_lo_q <= mask_lo_q & cur_bit;
				k_lo_q    <= k_lo_q - c_lo;
				res_lo_q  <= {res_lo_q[DATA_W-2:0], 1'b1};
			end
			if (take_hi0) begin
				mask_hi_q <= zero_hi;
				res_hi_q  <= {res_hi_q[DATA_W-2:0], 1'b0};
			end else begin
				mask_hi_q <= mask_hi_q & cur_bit;
				k_hi_q    <= k_hi_q - c_hi;
				res_hi_q  <= {res_hi_q[DATA_W-2:0], 1'b1};
			end
		end
	end

	assign done = done_q;
	assign lo   = sample_t'({~res_lo_q[DATA_W-1], res_lo_q[DATA_W-2:0]});
	assign hi   = sample_t'({~res_hi_q[DATA_W-1], res_hi_q[DATA_W-2:0]});

endmodule
`default_nettype wire

FILE: rtl/core/pose_median_filter_with_zero_offset.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pose_median_filter_with_zero_offset - windowed median of x/y with zero offset
// calibrates a mean offset, fills a sample ring, then emits median minus offset
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tdata: x_mm[15:0], y_mm[31:16]
// m_axis    out        m_axis_tvalid/tready      tdata: filtered_x_mm[16:0],
//                                                filtered_y_mm[33:17], zero pad
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// calibration and fill items are handled in the idle state; the last calibration item
// starts the serial offset dividers (one quotient bit per cycle)
// a median item goes through load, 16 bit steps of the rank unit, then output
// the median result waits in its output register when m_axis stalls; the
// block takes new items meanwhile unless the next result needs that register
// asynchronous active-low reset restores register defaults and clears counters
// the ring has no reset, entries are always written before they are ranked
//
module pose_median_filter_with_zero_offset #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pmf_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // x_mm, y_mm

	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [pmf_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // filtered_x_mm, filtered_y_mm, pad

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pmf_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CMP_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0]          state_q;

	// configuration registers
	logic [CALIB_W-1:0]  init_samples_q;
	logic [WLEN_W-1:0]   window_len_q;

	// calibration state
	logic [CALIB_W-1:0]  calib_count_q;
	sum_t                sum_x_q;
	sum_t                sum_y_q;
	sample_t             offset_x_q;
	sample_t             offset_y_q;
	logic                div_start_q;

	// ring state
	logic [CNT_W-1:0]    fill_count_q;
	logic [SLOT_W-1:0]   oldest_slot_q;
	sample_t             ring_x_q [WINDOW_DEPTH];
	sample_t             ring_y_q [WINDOW_DEPTH];

	// output register
	logic                m_valid_q;
	result_t             m_x_q;
	result_t             m_y_q;

	sample_t             in_x;
	sample_t             in_y;
	logic                accept;
	logic [CMP_W-1:0]    wlen_ext;
	logic [CNT_W-1:0]    w_eff;
	logic                in_calib;
	logic                in_fill;
	logic                in_med;
	logic [CALIB_W-1:0]  calib_next;
	logic [CNT_W-1:0]    slot_ext;
	logic [CNT_W-1:0]    slot_cur;
	logic [CNT_W-1:0]    slot_inc;
	logic [SLOT_W-1:0]   slot_next;
	logic [SLOT_W-1:0]   wr_slot;
	logic                ring_we;
	logic                rank_load;

	logic                div_x_done;
	logic                div_y_done;
	sample_t             quot_x;
	sample_t             quot_y;

	logic                rank_x_done;
	logic                rank_y_done;
	sample_t             lo_x;
	sample_t             hi_x;
	sample_t             lo_y;
	sample_t             hi_y;

	result_t             pair_x;
	result_t             pair_y;
	result_t             med_x;
	result_t             med_y;
	result_t             filt_x;
	result_t             filt_y;
	logic                slot_free;
	logic                out_load;

	assign in_x   = sample_t'(s_axis_tdata[DATA_W-1:0]);
	assign in_y   = sample_t'(s_axis_tdata[2*DATA_W-1:DATA_W]);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	// effective window: zero acts as one, clipped to the ring depth
	assign wlen_ext = CMP_W'(window_len_q);
	always_comb begin
		if (wlen_ext == '0) begin
			w_eff = CNT_W'(1);
		end else if (wlen_ext > CMP_W'(WINDOW_DEPTH)) begin
			w_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			w_eff = CNT_W'(wlen_ext);
		end
	end

	// which phase the next item belongs to
	assign in_calib   = calib_count_q < init_samples_q;
	assign in_fill    = !in_calib && (fill_count_q < w_eff);
	assign in_med     = !in_calib && !in_fill;
	assign calib_next = calib_count_q + 1'b1;

	// replacement slot, restarted when the window shrank below it
	assign slot_ext  = CNT_W'(oldest_slot_q);
	assign slot_cur  = (slot_ext >= w_eff) ? '0 : slot_ext;
	assign slot_inc  = slot_cur + 1'b1;
	assign slot_next = (slot_inc >= w_eff) ? '0 : slot_inc[SLOT_W-1:0];

	assign ring_we   = accept && !in_calib;
	assign wr_slot   = in_fill ? fill_count_q[SLOT_W-1:0] : slot_cur[SLOT_W-1:0];
	assign rank_load = accept && in_med;

	// median is the floor of the mean of the two middle ranks
	assign pair_x = result_t'(lo_x) + result_t'(hi_x);
	assign pair_y = result_t'(lo_y) + result_t'(hi_y);
	assign med_x  = pair_x >>> 1;
	assign med_y  = pair_y >>> 1;
	assign filt_x = med_x - result_t'(offset_x_q);
	assign filt_y = med_y - result_t'(offset_y_q);

	assign slot_free = !m_valid_q || m_axis_tready;
	assign out_load  = slot_free &&
	                   (((state_q == ST_SEL) && rank_x_done && rank_y_done) ||
	                    (state_q == ST_PUSH));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_samples_q <= INIT_SAMPLES_RST;
			window_len_q   <= WINDOW_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INIT_SAMPLES: init_samples_q <= cfg_data[CALIB_W-1:0];
				REG_WINDOW_LEN:   window_len_q   <= cfg_data[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, calibration and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			calib_count_q <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			div_start_q   <= 1'b0;
			fill_count_q  <= '0;
			oldest_slot_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_calib) begin
							sum_x_q       <= sum_x_q + SUM_W'(in_x);
							sum_y_q       <= sum_y_q + SUM_W'(in_y);
							calib_count_q <= calib_next;
							if (calib_next == init_samples_q) begin
								div_start_q <= 1'b1;
								state_q     <= ST_DIV;
							end
						end else if (in_fill) begin
							fill_count_q <= fill_count_q + 1'b1;
						end else begin
							oldest_slot_q <= slot_next;
							state_q       <= ST_SEL;
						end
					end
				end
				ST_DIV: begin
					if (div_x_done && div_y_done) begin
						offset_x_q <= quot_x;
						offset_y_q <= quot_y;
						state_q    <= ST_IDLE;
					end
				end
				ST_SEL: begin
					if (rank_x_done && rank_y_done) begin
						state_q <= slot_free ? ST_IDLE : ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample ring, written by fill and replacement items
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_x_q[wr_slot] <= in_x;
			ring_y_q[wr_slot] <= in_y;
		end
	end

	// result register toward m_axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_x_q <= filt_x;
			m_y_q <= filt_y;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_y_q, m_x_q};

	// offset dividers, one per axis, started together
	pmf_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_x_q),
		.divisor  (init_samples_q),
		.done     (div_x_done),
		.quotient (quot_x)
	);

	pmf_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_y_q),
		.divisor  (init_samples_q),
		.done     (div_y_done),
		.quotient (quot_y)
	);

	// rank units take a snapshot of the ring before the replacement write
	pmf_rank #(
		.DEPTH (WINDOW_DEPTH),
		.CNT_W (CNT_W)
	) u_rank_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (rank_load),
		.entries (ring_x_q),
		.win     (w_eff),
		.done    (rank_x_done),
		.lo      (lo_x),
		.hi      (hi_x)
	);

	pmf_rank #(
		.DEPTH (WINDOW_DEPTH),
		.CNT_W (CNT_W)
	) u_rank_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (rank_load),
		.entries (ring_y_q),
		.win     (w_eff),
		.done    (rank_y_done),
		.lo      (lo_y),
		.hi      (hi_y)
	);

endmodule
`default_nettype wire
